/* sv/mpm_contact_momentum_exchange_macros.svh */
// assertion macros shared by the contact exchange rtl
`ifndef MPM_CONTACT_MOMENTUM_EXCHANGE_MACROS_SVH
`define MPM_CONTACT_MOMENTUM_EXCHANGE_MACROS_SVH
`ifndef NO_ASSERTIONS
// concurrent check, disabled while reset is asserted
`define MCME_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent check that also holds during reset
`define MCME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCME_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCME_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/mcme_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mcme_pkg;

	// field widths
	localparam int VEL_W       = 32;
	localparam int MASS_W      = 32;
	localparam int GRAD_W      = 21;
	localparam int GRAD_PACK_W = 3 * GRAD_W;
	localparam int STATUS_W    = 2;

	// fixed point scaling
	localparam int NORM_SHIFT   = 20;
	localparam int UNIT_SHIFT   = 40;
	localparam int WEIGHT_SHIFT = 30;
	localparam int PROD_SHIFT   = 31;

	// iterative units: one result bit per stage
	localparam int ROOT_BITS = 31;
	localparam int QUO_BITS  = 31;

	localparam int UNIT_DIVIDEND_W   = GRAD_W + UNIT_SHIFT;
	localparam int WEIGHT_DIVIDEND_W = MASS_W + WEIGHT_SHIFT;
	localparam int MSUM_W            = MASS_W + 1;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_EXCHANGED  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SEPARATING = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd2;

	typedef struct packed {
		logic [MASS_W-1:0]      mass_r;
		logic [MASS_W-1:0]      mass_s;
		logic [VEL_W-1:0]       vel_r_x;
		logic [VEL_W-1:0]       vel_r_y;
		logic [VEL_W-1:0]       vel_r_z;
		logic [VEL_W-1:0]       vel_s_x;
		logic [VEL_W-1:0]       vel_s_y;
		logic [VEL_W-1:0]       vel_s_z;
		logic [GRAD_PACK_W-1:0] grad_r_packed;
		logic [GRAD_PACK_W-1:0] grad_s_packed;
	} mcme_in_t;

	typedef struct packed {
		logic [VEL_W-1:0]    new_vel_r_x;
		logic [VEL_W-1:0]    new_vel_r_y;
		logic [VEL_W-1:0]    new_vel_r_z;
		logic [VEL_W-1:0]    new_vel_s_x;
		logic [VEL_W-1:0]    new_vel_s_y;
		logic [VEL_W-1:0]    new_vel_s_z;
		logic [STATUS_W-1:0] status;
	} mcme_out_t;

endpackage
`default_nettype wire

/* sv/mcme_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface mcme_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/mcme_div_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none
module mcme_div_pipe
	import mcme_pkg::*;
#(
	parameter int DIVIDEND_W = UNIT_DIVIDEND_W,
	parameter int DIVISOR_W  = ROOT_BITS,
	parameter int QUO_W      = QUO_BITS
) (
	input  logic                  clk,
	input  logic                  adv,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [QUO_W-1:0]      quotient
);
	// remainder wide enough for the dividend and the top trial
	localparam int REM_W = (DIVIDEND_W > DIVISOR_W + QUO_W) ? DIVIDEND_W : DIVISOR_W + QUO_W;

	logic [REM_W-1:0]     rem_sn [QUO_W];
	logic [DIVISOR_W-1:0] div_sn [QUO_W];
	logic [QUO_W-1:0]     quo_sn [QUO_W];

	// restoring division, one quotient bit per stage, msb first
	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		localparam int K = QUO_W - 1 - i;
		logic [REM_W-1:0]     rem_in;
		logic [REM_W-1:0]     trial;
		logic [DIVISOR_W-1:0] div_in;
		logic [QUO_W-1:0]     quo_in;

		if (i == 0) begin : g_first
			assign rem_in = REM_W'(dividend);
			assign div_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sn[i-1];
			assign div_in = div_sn[i-1];
			assign quo_in = quo_sn[i-1];
		end

		assign trial = REM_W'(div_in) << K;

		always_ff @(posedge clk) begin
			if (adv) begin
				div_sn[i] <= div_in;
				if (rem_in >= trial) begin
					rem_sn[i] <= rem_in - trial;
					quo_sn[i] <= quo_in | (QUO_W'(1) << K);
				end else begin
					rem_sn[i] <= rem_in;
					quo_sn[i] <= quo_in;
				end
			end
		end
	end

	assign quotient = quo_sn[QUO_W-1];

endmodule
`default_nettype wire

/* sv/mcme_sqrt_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none
module mcme_sqrt_pipe
	import mcme_pkg::*;
#(
	parameter int ROOT_W = ROOT_BITS
) (
	input  logic                  clk,
	input  logic                  adv,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic [ROOT_W-1:0]     root
);
	localparam int X_W = 2 * ROOT_W;
	localparam int T_W = X_W + 1;

	logic [X_W-1:0]    rem_sn  [ROOT_W];
	logic [ROOT_W-1:0] root_sn [ROOT_W];

	// digit by digit floor root, one root bit per stage, msb first
	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam int K = ROOT_W - 1 - i;
		logic [X_W-1:0]    rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [T_W-1:0]    trial;

		if (i == 0) begin : g_first
			assign rem_in  = radicand;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_sn[i-1];
			assign root_in = root_sn[i-1];
		end

		// (root + 2^k)^2 - root^2
		assign trial = (T_W'(root_in) << (K + 1)) + (T_W'(1) << (2 * K));

		always_ff @(posedge clk) begin
			if (adv) begin
				if (T_W'(rem_in) >= trial) begin
					rem_sn[i]  <= X_W'(T_W'(rem_in) - trial);
					root_sn[i] <= root_in | (ROOT_W'(1) << K);
				end else begin
					rem_sn[i]  <= rem_in;
					root_sn[i] <= root_in;
				end
			end
		end
	end

	assign root = root_sn[ROOT_W-1];

endmodule
`default_nettype wire

/* sv/mpm_contact_momentum_exchange.sv */
// channel  modport  payload     role
// node     sink     mcme_in_t   masses, velocities, gradients of one grid node
// result   source   mcme_out_t  corrected velocities and status
//
// one node per cycle while the skid entry is empty. each node passes through
// the 31-step root pipeline and the 31-step divide pipelines that form the
// unit gradients and mass weights.
// reset clears the stage valid bits and the two-entry output buffer.
// a stalled result sits in the buffer; the pipeline keeps moving until
// the second buffer entry fills, then freezes with nothing lost.
`timescale 1ns / 1ps
`default_nettype none
`include "mpm_contact_momentum_exchange_macros.svh"
module mpm_contact_momentum_exchange
	import mcme_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	mcme_stream_if.sink   node,
	mcme_stream_if.source result
);
	// stage indices
	localparam int ST_CAP   = 0;
	localparam int ST_SUM   = 1;
	localparam int ST_ROOT0 = 2;
	localparam int ST_DIV0  = ST_ROOT0 + ROOT_BITS;
	localparam int ST_NRM   = ST_DIV0 + QUO_BITS;
	localparam int ST_COR   = ST_NRM + 4;

	localparam int SQ_W    = 2 * GRAD_W - 1;
	localparam int SUMSQ_W = SQ_W + 2;
	localparam int RAD_W   = 2 * ROOT_BITS;
	localparam int N_W     = QUO_BITS + 2;
	localparam int DV_W    = VEL_W + 1;
	localparam int PROD_W  = N_W + DV_W;
	localparam int TERM_W  = PROD_W - PROD_SHIFT;
	localparam int PROJ_W  = TERM_W + 1;
	localparam int P_W     = 33;
	localparam int AW_W    = P_W + QUO_BITS;
	localparam int MN_W    = N_W - 1;
	localparam int CORR_W  = P_W + MN_W;
	localparam int D_W     = CORR_W - PROD_SHIFT;
	localparam int NV_W    = D_W + 1;

	typedef struct packed {
		logic [2:0][VEL_W-1:0]  vr;
		logic [2:0][VEL_W-1:0]  vs;
		logic [2:0][GRAD_W-1:0] gmag_r;
		logic [2:0][GRAD_W-1:0] gmag_s;
		logic [2:0]             gneg_r;
		logic [2:0]             gneg_s;
		logic [MASS_W-1:0]      mass_r;
		logic [MASS_W-1:0]      mass_s;
		logic [MSUM_W-1:0]      msum;
		logic                   degen;
	} head_t;

	typedef struct packed {
		logic [2:0][VEL_W-1:0] vr;
		logic [2:0][VEL_W-1:0] vs;
		logic [2:0][N_W-1:0]   n;
		logic [QUO_BITS-1:0]   wr;
		logic [QUO_BITS-1:0]   ws;
		logic                  degen;
		logic                  sep;
	} tail_t;

	logic            adv;
	logic            push;
	logic            pop;
	logic [ST_COR:0] valid_s;

	head_t head_in;
	head_t head_sum;
	head_t head_s [ST_NRM];

	logic [2*GRAD_W-1:0] sq_full_r [3];
	logic [2*GRAD_W-1:0] sq_full_s [3];
	logic [SQ_W-1:0]     sq_r_s1 [3];
	logic [SQ_W-1:0]     sq_s_s1 [3];
	logic [SUMSQ_W-1:0]  sumsq_r;
	logic [SUMSQ_W-1:0]  sumsq_s;
	logic [RAD_W-1:0]    rad_r_s2;
	logic [RAD_W-1:0]    rad_s_s2;

	logic [ROOT_BITS-1:0] norm_r;
	logic [ROOT_BITS-1:0] norm_s;
	logic [QUO_BITS-1:0]  quo_r [3];
	logic [QUO_BITS-1:0]  quo_s [3];
	logic [QUO_BITS-1:0]  wr_q;
	logic [QUO_BITS-1:0]  ws_q;

	tail_t tail_nrm;
	tail_t tail_sep;
	tail_t tail_s65;
	tail_t tail_s66;
	tail_t tail_s67;
	tail_t tail_s68;
	tail_t tail_s69;

	logic [2:0][DV_W-1:0]       dv_nrm;
	logic [2:0][DV_W-1:0]       dv_s65;
	logic signed [PROD_W-1:0]   prod_s66 [3];
	logic signed [TERM_W-1:0]   term [3];
	logic signed [PROJ_W-1:0]   proj;
	logic signed [PROJ_W-1:0]   proj_s67;
	logic [P_W-1:0]             p_clamp;
	logic [AW_W-1:0]            arw_s68;
	logic [AW_W-1:0]            asw_s68;
	logic [P_W-1:0]             ar;
	logic [P_W-1:0]             as_w;
	logic [MN_W-1:0]            mn [3];
	logic [CORR_W-1:0]          corr_r_s69 [3];
	logic [CORR_W-1:0]          corr_s_s69 [3];

	mcme_out_t res_d;
	mcme_out_t out_q;
	mcme_out_t skid_q;
	logic      out_vq;
	logic      skid_vq;

	// flow control: pipeline runs unless the skid entry is occupied
	assign adv        = !skid_vq;
	assign push       = adv && valid_s[ST_COR];
	assign pop        = out_vq && result.ready;
	assign node.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[ST_COR-1:0], node.valid};
		end
	end

	// unpack the node, gradient magnitudes and signs
	always_comb begin
		logic [GRAD_W-1:0] gr;
		logic [GRAD_W-1:0] gs;
		head_in.vr     = {node.payload.vel_r_z, node.payload.vel_r_y, node.payload.vel_r_x};
		head_in.vs     = {node.payload.vel_s_z, node.payload.vel_s_y, node.payload.vel_s_x};
		head_in.mass_r = node.payload.mass_r;
		head_in.mass_s = node.payload.mass_s;
		head_in.msum   = MSUM_W'(node.payload.mass_r) + MSUM_W'(node.payload.mass_s);
		head_in.degen  = (node.payload.mass_r == '0) || (node.payload.mass_s == '0);
		for (int i = 0; i < 3; i++) begin
			gr = node.payload.grad_r_packed[i*GRAD_W +: GRAD_W];
			gs = node.payload.grad_s_packed[i*GRAD_W +: GRAD_W];
			head_in.gneg_r[i] = gr[GRAD_W-1];
			head_in.gneg_s[i] = gs[GRAD_W-1];
			head_in.gmag_r[i] = gr[GRAD_W-1] ? (~gr + 1'b1) : gr;
			head_in.gmag_s[i] = gs[GRAD_W-1] ? (~gs + 1'b1) : gs;
		end
	end

	// squared gradient components
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_full_r[i] = head_in.gmag_r[i] * head_in.gmag_r[i];
			sq_full_s[i] = head_in.gmag_s[i] * head_in.gmag_s[i];
		end
	end

	// sum of squares and zero-gradient check
	always_comb begin
		sumsq_r = SUMSQ_W'(sq_r_s1[0]) + SUMSQ_W'(sq_r_s1[1]) + SUMSQ_W'(sq_r_s1[2]);
		sumsq_s = SUMSQ_W'(sq_s_s1[0]) + SUMSQ_W'(sq_s_s1[1]) + SUMSQ_W'(sq_s_s1[2]);
		head_sum       = head_s[ST_CAP];
		head_sum.degen = head_s[ST_CAP].degen || (sumsq_r == '0) || (sumsq_s == '0);
	end

	// front stages and the sideband line beside the root and divide units
	always_ff @(posedge clk) begin
		if (adv) begin
			head_s[ST_CAP] <= head_in;
			for (int i = 0; i < 3; i++) begin
				sq_r_s1[i] <= sq_full_r[i][SQ_W-1:0];
				sq_s_s1[i] <= sq_full_s[i][SQ_W-1:0];
			end
			head_s[ST_SUM] <= head_sum;
			rad_r_s2       <= RAD_W'(sumsq_r) << NORM_SHIFT;
			rad_s_s2       <= RAD_W'(sumsq_s) << NORM_SHIFT;
			for (int k = ST_ROOT0; k < ST_NRM; k++) begin
				head_s[k] <= head_s[k-1];
			end
		end
	end

	// gradient norms
	mcme_sqrt_pipe #(
		.ROOT_W (ROOT_BITS)
	) u_sqrt_r (
		.clk      (clk),
		.adv      (adv),
		.radicand (rad_r_s2),
		.root     (norm_r)
	);

	mcme_sqrt_pipe #(
		.ROOT_W (ROOT_BITS)
	) u_sqrt_s (
		.clk      (clk),
		.adv      (adv),
		.radicand (rad_s_s2),
		.root     (norm_s)
	);

	// unit gradient magnitudes
	for (genvar i = 0; i < 3; i++) begin : g_unit
		mcme_div_pipe #(
			.DIVIDEND_W (UNIT_DIVIDEND_W),
			.DIVISOR_W  (ROOT_BITS),
			.QUO_W      (QUO_BITS)
		) u_div_r (
			.clk      (clk),
			.adv      (adv),
			.dividend (UNIT_DIVIDEND_W'(head_s[ST_DIV0-1].gmag_r[i]) << UNIT_SHIFT),
			.divisor  (norm_r),
			.quotient (quo_r[i])
		);

		mcme_div_pipe #(
			.DIVIDEND_W (UNIT_DIVIDEND_W),
			.DIVISOR_W  (ROOT_BITS),
			.QUO_W      (QUO_BITS)
		) u_div_s (
			.clk      (clk),
			.adv      (adv),
			.dividend (UNIT_DIVIDEND_W'(head_s[ST_DIV0-1].gmag_s[i]) << UNIT_SHIFT),
			.divisor  (norm_s),
			.quotient (quo_s[i])
		);
	end

	// mass weights over the mass sum
	mcme_div_pipe #(
		.DIVIDEND_W (WEIGHT_DIVIDEND_W),
		.DIVISOR_W  (MSUM_W),
		.QUO_W      (QUO_BITS)
	) u_div_wr (
		.clk      (clk),
		.adv      (adv),
		.dividend (WEIGHT_DIVIDEND_W'(head_s[ST_DIV0-1].mass_s) << WEIGHT_SHIFT),
		.divisor  (head_s[ST_DIV0-1].msum),
		.quotient (wr_q)
	);

	mcme_div_pipe #(
		.DIVIDEND_W (WEIGHT_DIVIDEND_W),
		.DIVISOR_W  (MSUM_W),
		.QUO_W      (QUO_BITS)
	) u_div_ws (
		.clk      (clk),
		.adv      (adv),
		.dividend (WEIGHT_DIVIDEND_W'(head_s[ST_DIV0-1].mass_r) << WEIGHT_SHIFT),
		.divisor  (head_s[ST_DIV0-1].msum),
		.quotient (ws_q)
	);

	// contact normal and relative velocity
	always_comb begin
		logic signed [N_W-1:0] ur;
		logic signed [N_W-1:0] us;
		tail_nrm.vr    = head_s[ST_NRM-1].vr;
		tail_nrm.vs    = head_s[ST_NRM-1].vs;
		tail_nrm.wr    = wr_q;
		tail_nrm.ws    = ws_q;
		tail_nrm.degen = head_s[ST_NRM-1].degen;
		tail_nrm.sep   = 1'b0;
		for (int i = 0; i < 3; i++) begin
			ur = head_s[ST_NRM-1].gneg_r[i] ? -$signed(N_W'(quo_r[i])) : $signed(N_W'(quo_r[i]));
			us = head_s[ST_NRM-1].gneg_s[i] ? -$signed(N_W'(quo_s[i])) : $signed(N_W'(quo_s[i]));
			tail_nrm.n[i] = ur - us;
			dv_nrm[i]     = DV_W'($signed(head_s[ST_NRM-1].vr[i]))
			              - DV_W'($signed(head_s[ST_NRM-1].vs[i]));
		end
	end

	// projection terms truncated toward zero
	always_comb begin
		logic signed [PROD_W-1:0] sh;
		for (int i = 0; i < 3; i++) begin
			sh      = prod_s66[i] >>> PROD_SHIFT;
			term[i] = $signed(sh[TERM_W-1:0])
			        + $signed(TERM_W'(prod_s66[i][PROD_W-1] && (prod_s66[i][PROD_SHIFT-1:0] != '0)));
		end
		proj = PROJ_W'(term[0]) + PROJ_W'(term[1]) + PROJ_W'(term[2]);
	end

	// clamp the positive projection
	assign p_clamp = (proj_s67[PROJ_W-2:P_W] != '0) ? '1 : proj_s67[P_W-1:0];

	// separation flag joins the tail at the weight stage
	always_comb begin
		tail_sep     = tail_s67;
		tail_sep.sep = proj_s67[PROJ_W-1] || (proj_s67 == '0);
	end

	// scaled projections and normal magnitudes
	assign ar   = arw_s68[WEIGHT_SHIFT +: P_W];
	assign as_w = asw_s68[WEIGHT_SHIFT +: P_W];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mn[i] = tail_s68.n[i][N_W-1] ? MN_W'(-tail_s68.n[i]) : tail_s68.n[i][MN_W-1:0];
		end
	end

	// back stages
	always_ff @(posedge clk) begin
		if (adv) begin
			tail_s65 <= tail_nrm;
			dv_s65   <= dv_nrm;

			tail_s66 <= tail_s65;
			for (int i = 0; i < 3; i++) begin
				prod_s66[i] <= $signed(PROD_W'($signed(dv_s65[i])))
				             * $signed(PROD_W'($signed(tail_s65.n[i])));
			end

			tail_s67 <= tail_s66;
			proj_s67 <= proj;

			tail_s68 <= tail_sep;
			arw_s68  <= AW_W'(p_clamp) * AW_W'(tail_s67.wr);
			asw_s68  <= AW_W'(p_clamp) * AW_W'(tail_s67.ws);

			tail_s69 <= tail_s68;
			for (int i = 0; i < 3; i++) begin
				corr_r_s69[i] <= CORR_W'(ar) * CORR_W'(mn[i]);
				corr_s_s69[i] <= CORR_W'(as_w) * CORR_W'(mn[i]);
			end
		end
	end

	// apply corrections, saturate, select status
	always_comb begin
		logic [D_W-1:0]         dr;
		logic [D_W-1:0]         ds;
		logic signed [NV_W-1:0] nr;
		logic signed [NV_W-1:0] ns;
		logic [2:0][VEL_W-1:0]  vr_new;
		logic [2:0][VEL_W-1:0]  vs_new;
		for (int i = 0; i < 3; i++) begin
			dr = corr_r_s69[i][PROD_SHIFT +: D_W];
			ds = corr_s_s69[i][PROD_SHIFT +: D_W];
			if (tail_s69.n[i][N_W-1]) begin
				nr = NV_W'($signed(tail_s69.vr[i])) + $signed(NV_W'(dr));
				ns = NV_W'($signed(tail_s69.vs[i])) - $signed(NV_W'(ds));
			end else begin
				nr = NV_W'($signed(tail_s69.vr[i])) - $signed(NV_W'(dr));
				ns = NV_W'($signed(tail_s69.vs[i])) + $signed(NV_W'(ds));
			end
			if (nr[NV_W-1:VEL_W-1] == '0 || nr[NV_W-1:VEL_W-1] == '1) begin
				vr_new[i] = nr[VEL_W-1:0];
			end else begin
				vr_new[i] = {nr[NV_W-1], {(VEL_W-1){~nr[NV_W-1]}}};
			end
			if (ns[NV_W-1:VEL_W-1] == '0 || ns[NV_W-1:VEL_W-1] == '1) begin
				vs_new[i] = ns[VEL_W-1:0];
			end else begin
				vs_new[i] = {ns[NV_W-1], {(VEL_W-1){~ns[NV_W-1]}}};
			end
		end
		if (tail_s69.degen || tail_s69.sep) begin
			vr_new = tail_s69.vr;
			vs_new = tail_s69.vs;
		end
		res_d.new_vel_r_x = vr_new[0];
		res_d.new_vel_r_y = vr_new[1];
		res_d.new_vel_r_z = vr_new[2];
		res_d.new_vel_s_x = vs_new[0];
		res_d.new_vel_s_y = vs_new[1];
		res_d.new_vel_s_z = vs_new[2];
		if (tail_s69.degen) begin
			res_d.status = STATUS_DEGENERATE;
		end else if (tail_s69.sep) begin
			res_d.status = STATUS_SEPARATING;
		end else begin
			res_d.status = STATUS_EXCHANGED;
		end
	end

	// two-entry output buffer, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vq  <= 1'b0;
			skid_vq <= 1'b0;
		end else if (skid_vq) begin
			if (pop) begin
				skid_vq <= 1'b0;
			end
		end else if (push) begin
			if (!out_vq || pop) begin
				out_vq <= 1'b1;
			end else begin
				skid_vq <= 1'b1;
			end
		end else if (pop) begin
			out_vq <= 1'b0;
		end
	end

	// two-entry output buffer, payload
	always_ff @(posedge clk) begin
		if (skid_vq) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_vq || pop) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

	assign result.valid   = out_vq;
	assign result.payload = out_q;

	// checks
	`MCME_ASSERT_ALWAYS(a_skid_implies_out, clk, skid_vq |-> out_vq, "skid entry without head entry")
	`MCME_ASSERT(a_skid_fill, clk, arst_n, $rose(skid_vq) |-> $past(out_vq && !result.ready), "skid filled while head drained")
	`MCME_ASSERT(a_last_held, clk, arst_n, (!adv && valid_s[ST_COR]) |=> valid_s[ST_COR], "stalled item lost")
	`MCME_ASSERT(a_status_code, clk, arst_n, out_vq |-> (out_q.status == STATUS_EXCHANGED || out_q.status == STATUS_SEPARATING || out_q.status == STATUS_DEGENERATE), "bad status code")

endmodule
`default_nettype wire
